[rtl/ppurt_pkg.sv]
// Shared types and constants for the picture-unit register port and frame timer.
// Used by every module of the block except ppurt_ram; depends on nothing.
package ppurt_pkg;

  localparam int WARMUP_DOTS     = 90000;
  localparam int DOTS_PER_LINE   = 341;
  localparam int LINES_PER_FRAME = 262;
  localparam int SPRITE_BYTES    = 256;
  localparam int SPRITE_AW       = $clog2(SPRITE_BYTES);

  localparam logic [16:0] WARMUP_LIMIT = 17'(WARMUP_DOTS);
  localparam logic [8:0]  DOT_LAST     = 9'(DOTS_PER_LINE - 1);
  localparam logic [9:0]  LINE_WRAP    = 10'(LINES_PER_FRAME);
  localparam logic [8:0]  VBLANK_LINE  = 9'd241;
  localparam logic [8:0]  PRERENDER_LINE = 9'd261;
  localparam logic [8:0]  EDGE_DOT     = 9'd1;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic [7:0] vram_read_data;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        vram_write_enable;
    logic [13:0] vram_address;
    logic [7:0]  vram_write_data;
    logic        nmi_pulse;
    logic        in_vblank;
  } rsp_t;

  typedef struct packed {
    rsp_t rsp;
    logic oam_read;
  } stage_t;

endpackage

[rtl/ppurt_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; no package needed.
module ppurt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/ppurt_state.sv]
// Register file, scroll/address logic, frame timer and sprite memory.
// Depends on ppurt_pkg and ppurt_ram.
module ppurt_state (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  ppurt_pkg::req_t     req,
  output ppurt_pkg::stage_t   stage,
  output logic [7:0]          oam_rdata
);

  logic [14:0] temp_address, temp_address_next;
  logic [14:0] current_address, current_address_next;
  logic        write_toggle, write_toggle_next;
  logic [2:0]  status_bits, status_bits_next;
  logic [ppurt_pkg::SPRITE_AW-1:0] sprite_addr, sprite_addr_next;
  logic [7:0]  shadow_ctrl, shadow_ctrl_next;
  logic [7:0]  shadow_mask, shadow_mask_next;
  logic [7:0]  shadow_spr_addr, shadow_spr_addr_next;
  logic [7:0]  shadow_scroll, shadow_scroll_next;
  logic [7:0]  shadow_addr, shadow_addr_next;
  logic [8:0]  dot_count, dot_count_next;
  logic [8:0]  line_count, line_count_next;
  logic [16:0] warmup_count, warmup_count_next;
  logic        warm_done, warm_done_next;
  logic [14:0] addr_step;
  logic [9:0]  line_plus;
  logic        oam_we;
  logic        oam_re;

  always_comb begin
    temp_address_next    = temp_address;
    current_address_next = current_address;
    write_toggle_next    = write_toggle;
    status_bits_next     = status_bits;
    sprite_addr_next     = sprite_addr;
    shadow_ctrl_next     = shadow_ctrl;
    shadow_mask_next     = shadow_mask;
    shadow_spr_addr_next = shadow_spr_addr;
    shadow_scroll_next   = shadow_scroll;
    shadow_addr_next     = shadow_addr;
    dot_count_next       = dot_count;
    line_count_next      = line_count;
    warmup_count_next    = warmup_count;
    warm_done_next       = warm_done;
    stage                = '0;
    oam_we               = 1'b0;
    oam_re               = 1'b0;
    addr_step            = shadow_ctrl[2] ? 15'h20 : 15'h01;
    line_plus            = {1'b0, line_count} + 10'd1;

    case (req.req_type)
      ppurt_pkg::REQ_TICK: begin
        if (warmup_count > ppurt_pkg::WARMUP_LIMIT) begin
          warm_done_next = 1'b1;
        end
        if (line_count == ppurt_pkg::VBLANK_LINE && dot_count == ppurt_pkg::EDGE_DOT) begin
          status_bits_next[2] = 1'b1;
          stage.rsp.nmi_pulse = shadow_ctrl[7];
        end else if (line_count == ppurt_pkg::PRERENDER_LINE &&
                     dot_count == ppurt_pkg::EDGE_DOT) begin
          status_bits_next[2] = 1'b0;
        end
        if (dot_count >= ppurt_pkg::DOT_LAST) begin
          dot_count_next = '0;
          if (line_plus >= ppurt_pkg::LINE_WRAP) begin
            line_count_next = '0;
          end else begin
            line_count_next = line_plus[8:0];
          end
        end else begin
          dot_count_next = dot_count + 9'd1;
        end
        if (warmup_count != '1) begin
          warmup_count_next = warmup_count + 17'd1;
        end
      end
      ppurt_pkg::REQ_READ: begin
        case (req.reg_index)
          ppurt_pkg::REG_STATUS: begin
            stage.rsp.read_data = {status_bits, temp_address[4:0]};
            status_bits_next[2] = 1'b0;
            write_toggle_next   = 1'b0;
          end
          ppurt_pkg::REG_OAM_DATA: begin
            oam_re         = 1'b1;
            stage.oam_read = 1'b1;
          end
          ppurt_pkg::REG_DATA: begin
            stage.rsp.read_data    = req.vram_read_data;
            stage.rsp.vram_address = current_address[13:0];
            current_address_next   = current_address + addr_step;
          end
          ppurt_pkg::REG_CTRL:     stage.rsp.read_data = shadow_ctrl;
          ppurt_pkg::REG_MASK:     stage.rsp.read_data = shadow_mask;
          ppurt_pkg::REG_OAM_ADDR: stage.rsp.read_data = shadow_spr_addr;
          ppurt_pkg::REG_SCROLL:   stage.rsp.read_data = shadow_scroll;
          ppurt_pkg::REG_ADDR:     stage.rsp.read_data = shadow_addr;
          default: ;
        endcase
      end
      ppurt_pkg::REQ_WRITE: begin
        case (req.reg_index)
          ppurt_pkg::REG_CTRL: begin
            if (warm_done) begin
              temp_address_next[11:10] = req.write_data[1:0];
              shadow_ctrl_next         = req.write_data;
            end
          end
          ppurt_pkg::REG_MASK: begin
            if (warm_done) begin
              shadow_mask_next = req.write_data;
            end
          end
          ppurt_pkg::REG_OAM_ADDR: begin
            sprite_addr_next     = req.write_data;
            shadow_spr_addr_next = req.write_data;
          end
          ppurt_pkg::REG_OAM_DATA: begin
            oam_we           = 1'b1;
            sprite_addr_next = sprite_addr + 8'd1;
          end
          ppurt_pkg::REG_SCROLL: begin
            if (!write_toggle) begin
              temp_address_next[4:0] = req.write_data[7:3];
              write_toggle_next      = 1'b1;
            end else begin
              temp_address_next[9:5]   = req.write_data[7:3];
              temp_address_next[14:12] = req.write_data[2:0];
              write_toggle_next        = 1'b0;
              shadow_scroll_next       = req.write_data;
            end
          end
          ppurt_pkg::REG_ADDR: begin
            if (!write_toggle) begin
              temp_address_next[13:8] = req.write_data[5:0];
              temp_address_next[14]   = 1'b0;
              write_toggle_next       = 1'b1;
            end else begin
              temp_address_next[7:0] = req.write_data;
              write_toggle_next      = 1'b0;
              current_address_next   = {temp_address[14:8], req.write_data};
              shadow_addr_next       = req.write_data;
            end
          end
          ppurt_pkg::REG_DATA: begin
            stage.rsp.vram_write_enable = 1'b1;
            stage.rsp.vram_address      = current_address[13:0];
            stage.rsp.vram_write_data   = req.write_data;
            current_address_next        = current_address + addr_step;
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    stage.rsp.in_vblank = status_bits_next[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_address    <= '0;
      current_address <= '0;
      write_toggle    <= 1'b0;
      status_bits     <= 3'b101;
      sprite_addr     <= '0;
      shadow_ctrl     <= '0;
      shadow_mask     <= '0;
      shadow_spr_addr <= '0;
      shadow_scroll   <= '0;
      shadow_addr     <= '0;
      dot_count       <= '0;
      line_count      <= '0;
      warmup_count    <= '0;
      warm_done       <= 1'b0;
    end else if (accept) begin
      temp_address    <= temp_address_next;
      current_address <= current_address_next;
      write_toggle    <= write_toggle_next;
      status_bits     <= status_bits_next;
      sprite_addr     <= sprite_addr_next;
      shadow_ctrl     <= shadow_ctrl_next;
      shadow_mask     <= shadow_mask_next;
      shadow_spr_addr <= shadow_spr_addr_next;
      shadow_scroll   <= shadow_scroll_next;
      shadow_addr     <= shadow_addr_next;
      dot_count       <= dot_count_next;
      line_count      <= line_count_next;
      warmup_count    <= warmup_count_next;
      warm_done       <= warm_done_next;
    end
  end

  ppurt_ram #(
    .WIDTH(8),
    .DEPTH(ppurt_pkg::SPRITE_BYTES)
  ) u_sprite_ram (
    .clk  (clk),
    .we   (accept && oam_we),
    .waddr(sprite_addr),
    .wdata(req.write_data),
    .re   (accept && oam_re),
    .raddr(sprite_addr),
    .rdata(oam_rdata)
  );

endmodule

[rtl/ppurt_pipe.sv]
// Result pipeline: one stage that waits on the sprite RAM read, then the output register.
// Depends on ppurt_pkg.
module ppurt_pipe (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  ppurt_pkg::stage_t stage,
  input  logic [7:0]        oam_rdata,
  output logic              ready,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output ppurt_pkg::rsp_t   rsp
);

  logic              s1_valid;
  ppurt_pkg::stage_t s1;
  logic              advance;
  ppurt_pkg::rsp_t   s1_rsp;

  assign advance = !rsp_valid || !rsp_stall;
  assign ready   = !s1_valid || advance;

  always_comb begin
    s1_rsp = s1.rsp;
    if (s1.oam_read) begin
      s1_rsp.read_data = oam_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (ready) begin
        s1_valid <= accept;
      end
      if (advance) begin
        rsp_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= stage;
    end
    if (advance && s1_valid) begin
      rsp <= s1_rsp;
    end
  end

endmodule

[rtl/ppu_register_port_and_frame_timing_top.sv]
// Top level of the picture-unit register port and frame timer.
// Depends on ppurt_pkg, ppurt_state, ppurt_pipe (and ppurt_ram below them).
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+---------------------------
//  request | req_valid / req_stall | req (ppurt_pkg::req_t)
//  result  | rsp_valid / rsp_stall | rsp (ppurt_pkg::rsp_t)
//
// One transaction per cycle is taken while req_stall is low; each result passes
// the registered read of the sprite RAM and then the output register.
// rst is synchronous; the sprite RAM is not cleared.
// req_stall rises only while both the RAM read stage and the output register are full
// and rsp_stall is high.
module ppu_register_port_and_frame_timing_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  ppurt_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output ppurt_pkg::rsp_t rsp
);

  logic              ready;
  logic              accept;
  ppurt_pkg::stage_t stage;
  logic [7:0]        oam_rdata;

  assign req_stall = !ready;
  assign accept    = req_valid && ready;

  ppurt_state u_state (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .req      (req),
    .stage    (stage),
    .oam_rdata(oam_rdata)
  );

  ppurt_pipe u_pipe (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .stage    (stage),
    .oam_rdata(oam_rdata),
    .ready    (ready),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

`ifndef ASSERT_OFF
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("request stalled while the output register can drain");

  a_nmi_in_vblank: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.nmi_pulse |-> rsp.in_vblank)
    else $error("nmi pulse without vblank");

  a_write_no_read: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.vram_write_enable |-> rsp.read_data == 8'd0 && !rsp.nmi_pulse)
    else $error("data-port write result carries read data or nmi");
`endif

endmodule
